/* sv/u8sc_pkg.sv */
// shared types, constants and byte classification for the utf-8 sanitizing copy core
package u8sc_pkg;

    // byte classes decided at the input side
    typedef enum logic [2:0] {
        CL_ASCII,
        CL_CONT,
        CL_LEAD2,
        CL_LEAD3,
        CL_LEAD4,
        CL_BAD
    } t_class;

    // one lookahead entry: raw byte plus its class
    typedef struct packed {
        logic [7:0] data;
        t_class     cls;
    } t_lbyte;

    // one queued input word
    typedef struct packed {
        t_lbyte lb;
        logic   eot;
        logic   is_zero;
    } t_qword;

    // configuration registers
    typedef struct packed {
        logic [15:0] source_limit;
        logic [15:0] dest_limit;
    } t_cfg;

    // back end sequencer states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_EMIT,
        ST_FINAL
    } t_state;

    // register indexes
    localparam logic [1:0] CFG_SOURCE_LIMIT = 2'd0;
    localparam logic [1:0] CFG_DEST_LIMIT   = 2'd1;

    localparam logic [15:0] SOURCE_LIMIT_RST = 16'd256;
    localparam logic [15:0] DEST_LIMIT_RST   = 16'd256;

    // byte constants
    localparam logic [7:0] CONT_MASK   = 8'hc0;
    localparam logic [7:0] CONT_TAG    = 8'h80;
    localparam logic [7:0] LEAD2_LO    = 8'hc2;
    localparam logic [7:0] LEAD2_HI    = 8'hdf;
    localparam logic [7:0] LEAD3_LO    = 8'he0;
    localparam logic [7:0] LEAD3_HI    = 8'hef;
    localparam logic [7:0] LEAD4_LO    = 8'hf0;
    localparam logic [7:0] LEAD4_HI    = 8'hf4;
    localparam logic [7:0] SURR_LEAD   = 8'hed;
    localparam logic [7:0] SEC3_BOUND  = 8'ha0;
    localparam logic [7:0] SEC4_BOUND  = 8'h90;
    localparam logic [7:0] REPL_BYTE0  = 8'hef;
    localparam logic [7:0] REPL_BYTE1  = 8'hbf;
    localparam logic [7:0] REPL_BYTE2  = 8'hbd;

    // classify one source byte
    function automatic t_class f_classify(input logic [7:0] b);
        t_class c;
        priority if (b < CONT_TAG) begin
            c = CL_ASCII;
        end else if ((b & CONT_MASK) == CONT_TAG) begin
            c = CL_CONT;
        end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            c = CL_LEAD2;
        end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            c = CL_LEAD3;
        end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            c = CL_LEAD4;
        end else begin
            c = CL_BAD;
        end
        return c;
    endfunction

    // sequence length started by a byte of this class
    function automatic logic [2:0] f_seq_len(input t_class c);
        logic [2:0] n;
        unique case (c)
            CL_LEAD2: n = 3'd2;
            CL_LEAD3: n = 3'd3;
            CL_LEAD4: n = 3'd4;
            default:  n = 3'd1;
        endcase
        return n;
    endfunction

endpackage

/* sv/u8sc_front.sv */
// input side: accepts source words and classifies each byte for the queue
module u8sc_front (
    input  logic            i_in_valid,
    input  logic [7:0]      i_data_byte,
    input  logic            i_end_of_text,
    input  logic            i_q_full,
    output logic            o_in_stall,
    output logic            o_push,
    output u8sc_pkg::t_qword o_word
);
    import u8sc_pkg::*;

    // hold the source off while the queue has no room
    assign o_in_stall = i_q_full;
    assign o_push     = i_in_valid && !i_q_full;

    // classify the byte on its way in
    always_comb begin
        o_word.lb.data = i_data_byte;
        o_word.lb.cls  = f_classify(i_data_byte);
        o_word.eot     = i_end_of_text;
        o_word.is_zero = (i_data_byte == 8'd0);
    end

endmodule

/* sv/u8sc_queue.sv */
// two-entry word queue between the input side and the sequencer
module u8sc_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u8sc_pkg::t_qword i_word,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output u8sc_pkg::t_qword o_word
);
    import u8sc_pkg::*;

    t_qword     r_mem [2];
    logic       r_wr_ptr, n_wr_ptr;
    logic       r_rd_ptr, n_rd_ptr;
    logic [1:0] r_count, n_count;

    assign o_full  = (r_count == 2'd2);
    assign o_empty = (r_count == 2'd0);
    assign o_word  = r_mem[r_rd_ptr];

    // pointer and count update
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = ~r_wr_ptr;
        end
        if (i_pop) begin
            n_rd_ptr = ~r_rd_ptr;
        end
        unique case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // word storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_word;
        end
    end

endmodule

/* sv/u8sc_back.sv */
// sequencer: lookahead buffer, sequence decision, copy or replacement, final count
module u8sc_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  u8sc_pkg::t_cfg   i_cfg,
    input  logic             i_q_empty,
    input  u8sc_pkg::t_qword i_q_word,
    output logic             o_q_pop,
    output logic             o_out_valid,
    input  logic             i_out_stall,
    output logic [7:0]       o_out_byte,
    output logic             o_done_res,
    output logic [15:0]      o_written_total
);
    import u8sc_pkg::*;

    localparam int CAP_W = (COUNT_BITS > 16) ? COUNT_BITS : 16;
    localparam logic [CAP_W:0] COUNT_MAX = (CAP_W + 1)'((64'd1 << COUNT_BITS) - 64'd1);
    localparam logic [COUNT_BITS-1:0] SEEN_MAX = '1;

    t_state                r_state, n_state;
    t_lbyte                r_buf [4];
    t_lbyte                n_buf [4];
    logic [2:0]            r_fill, n_fill;
    logic [COUNT_BITS-1:0] r_seen, n_seen;
    logic [COUNT_BITS-1:0] r_written, n_written;
    logic                  r_stopped, n_stopped;
    logic                  r_ended, n_ended;
    logic                  r_eot_pend, n_eot_pend;
    logic [1:0]            r_k, n_k;
    logic [2:0]            r_len, n_len;
    logic                  r_copy, n_copy;
    logic [2:0]            r_drop, n_drop;
    logic                  r_out_valid, n_out_valid;
    logic [7:0]            r_out_byte, n_out_byte;
    logic                  r_out_done, n_out_done;
    logic [15:0]           r_out_total, n_out_total;

    assign o_out_valid     = r_out_valid;
    assign o_out_byte      = r_out_byte;
    assign o_done_res      = r_out_done;
    assign o_written_total = r_out_total;

    // output register can take a word this cycle
    logic can_load;
    assign can_load = !r_out_valid || !i_out_stall;

    // sequence decision at the head of the buffer
    t_class     head_cls;
    logic [7:0] first_b, second_b;
    logic [2:0] cnt, emit_len;
    logic       multi, short_seq, cont_ok, range_ok, seq_valid, drain_done, over;
    logic [CAP_W:0] dest_ext, cap, need;

    assign head_cls  = r_buf[0].cls;
    assign first_b   = r_buf[0].data;
    assign second_b  = r_buf[1].data;
    assign cnt       = f_seq_len(head_cls);
    assign multi     = (cnt != 3'd1);
    assign short_seq = multi && (r_fill < cnt);
    assign cont_ok   = (r_buf[1].cls == CL_CONT)
                    && ((cnt < 3'd3) || (r_buf[2].cls == CL_CONT))
                    && ((cnt < 3'd4) || (r_buf[3].cls == CL_CONT));
    // overlong, surrogate and above-range forms
    assign range_ok  = !(((first_b == LEAD3_LO)  && (second_b <  SEC3_BOUND))
                      || ((first_b == SURR_LEAD) && (second_b >= SEC3_BOUND))
                      || ((first_b == LEAD4_LO)  && (second_b <  SEC4_BOUND))
                      || ((first_b == LEAD4_HI)  && (second_b >= SEC4_BOUND)));
    assign seq_valid  = (head_cls == CL_ASCII) || (multi && !short_seq && cont_ok && range_ok);
    assign drain_done = (r_fill == 3'd0) || r_stopped || (short_seq && !r_ended);
    assign emit_len   = seq_valid ? cnt : 3'd3;

    // capacity check against the destination limit
    assign dest_ext = (CAP_W + 1)'(i_cfg.dest_limit);
    assign cap      = (dest_ext < COUNT_MAX) ? dest_ext : COUNT_MAX;
    assign need     = (CAP_W + 1)'(r_written) + (CAP_W + 1)'(emit_len);
    assign over     = need > cap;

    // source limit checks
    logic [COUNT_BITS-1:0] seen_inc;
    logic                  seen_ge, inc_ge;
    assign seen_inc = (r_seen == SEEN_MAX) ? r_seen : r_seen + 1'b1;
    assign seen_ge  = CAP_W'(r_seen)   >= CAP_W'(i_cfg.source_limit);
    assign inc_ge   = CAP_W'(seen_inc) >= CAP_W'(i_cfg.source_limit);

    logic last_k;
    assign last_k = ({1'b0, r_k} == (r_len - 3'd1));

    // replacement character bytes
    logic [7:0] repl_b;
    always_comb begin
        unique case (r_k)
            2'd0:    repl_b = REPL_BYTE0;
            2'd1:    repl_b = REPL_BYTE1;
            default: repl_b = REPL_BYTE2;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty && (i_q_word.eot || !r_ended)) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_DECIDE: begin
                if (drain_done || over) begin
                    n_state = r_eot_pend ? ST_FINAL : ST_IDLE;
                end else begin
                    n_state = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (can_load && last_k) begin
                    n_state = ST_DECIDE;
                end
            end
            ST_FINAL: begin
                if ((i_cfg.dest_limit == 16'd0) || can_load) begin
                    n_state = ST_IDLE;
                end
            end
        endcase
    end

    // datapath and outputs
    always_comb begin
        int j;
        n_buf       = r_buf;
        n_fill      = r_fill;
        n_seen      = r_seen;
        n_written   = r_written;
        n_stopped   = r_stopped;
        n_ended     = r_ended;
        n_eot_pend  = r_eot_pend;
        n_k         = r_k;
        n_len       = r_len;
        n_copy      = r_copy;
        n_drop      = r_drop;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_done  = r_out_done;
        n_out_total = r_out_total;
        o_q_pop     = 1'b0;

        // word taken downstream
        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    if (i_q_word.eot) begin
                        n_ended    = 1'b1;
                        n_eot_pend = 1'b1;
                    end else if (!r_ended) begin
                        if (i_q_word.is_zero || seen_ge) begin
                            n_ended = 1'b1;
                        end else begin
                            if (r_fill < 3'd4) begin
                                n_buf[r_fill[1:0]] = i_q_word.lb;
                                n_fill = r_fill + 3'd1;
                            end
                            n_seen = seen_inc;
                            if (inc_ge) begin
                                n_ended = 1'b1;
                            end
                        end
                    end
                end
            end
            ST_DECIDE: begin
                if (drain_done) begin
                    if (r_stopped) begin
                        n_fill = 3'd0;
                    end
                end else if (over) begin
                    n_stopped = 1'b1;
                    n_fill    = 3'd0;
                end else begin
                    n_k    = 2'd0;
                    n_len  = emit_len;
                    n_copy = seq_valid;
                    n_drop = seq_valid ? cnt : 3'd1;
                end
            end
            ST_EMIT: begin
                if (can_load) begin
                    n_written   = r_written + 1'b1;
                    n_out_valid = 1'b1;
                    n_out_byte  = r_copy ? r_buf[r_k].data : repl_b;
                    n_out_done  = 1'b0;
                    n_out_total = 16'(n_written);
                    if (last_k) begin
                        // drop the consumed bytes from the front
                        for (j = 0; j < 4; j++) begin
                            if (j + int'(r_drop) < 4) begin
                                n_buf[j] = r_buf[2'(j + int'(r_drop))];
                            end
                        end
                        n_fill = (r_fill > r_drop) ? r_fill - r_drop : 3'd0;
                    end else begin
                        n_k = r_k + 2'd1;
                    end
                end
            end
            ST_FINAL: begin
                if ((i_cfg.dest_limit == 16'd0) || can_load) begin
                    if (i_cfg.dest_limit != 16'd0) begin
                        n_out_valid = 1'b1;
                        n_out_byte  = 8'd0;
                        n_out_done  = 1'b1;
                        n_out_total = 16'(r_written);
                    end
                    // start a new text
                    n_fill     = 3'd0;
                    n_seen     = '0;
                    n_written  = '0;
                    n_stopped  = 1'b0;
                    n_ended    = 1'b0;
                    n_eot_pend = 1'b0;
                end
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_fill      <= 3'd0;
            r_seen      <= '0;
            r_written   <= '0;
            r_stopped   <= 1'b0;
            r_ended     <= 1'b0;
            r_eot_pend  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_seen      <= n_seen;
            r_written   <= n_written;
            r_stopped   <= n_stopped;
            r_ended     <= n_ended;
            r_eot_pend  <= n_eot_pend;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_buf       <= n_buf;
        r_k         <= n_k;
        r_len       <= n_len;
        r_copy      <= n_copy;
        r_drop      <= n_drop;
        r_out_byte  <= n_out_byte;
        r_out_done  <= n_out_done;
        r_out_total <= n_out_total;
    end

`ifndef SYNTHESIS
    // emit index stays inside the current sequence
    a_emit_index: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> ({1'b0, r_k} < r_len))
        else $error("emit index past sequence length");

    // waiting for more bytes leaves room for the next one
    a_idle_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_fill <= 3'd3))
        else $error("buffer full while idle");

    // an ended text is fully drained before the next word
    a_ended_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_ended) |-> (r_fill == 3'd0))
        else $error("ended text left bytes in buffer");

    // stopped output discards the buffer
    a_stopped_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE && r_stopped) |-> (r_fill == 3'd0))
        else $error("stopped output kept buffered bytes");

    // a final word is followed by a cleared text
    a_final_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINAL && n_state == ST_IDLE) |=> (r_written == '0 && !r_ended))
        else $error("text state not cleared after final word");
`endif

endmodule

/* sv/utf8_sanitize_copy_core.sv */
// utf-8 sanitizing copy core: config registers, input side, queue and sequencer
//
//  channel | direction | handshake                      | payload
//  --------+-----------+--------------------------------+-----------------------------------
//  in      | sink      | i_in_valid / o_in_stall        | i_data_byte, i_end_of_text
//  out     | source    | o_out_valid / i_out_stall      | o_out_byte, o_done_res,
//          |           |                                | o_written_total
//  cfg     | sink      | i_cfg_valid / o_cfg_ready      | i_cfg_index, i_cfg_data
//
//  a source byte is loaded into the buffer, then decided at the head, then emitted word by word;
//  a replaced byte is emitted as the three replacement bytes, and every further sequence drained
//  from the buffer adds a decision plus its output words
//  an end of text with an empty buffer goes through load, decision and final word (no final word at dest limit 0)
//  the output register holds one word, so a stalled output holds the sequencer in its emit state
//  a two-word queue lets the input side keep accepting while the output is stalled, until the queue is full
//  reset is synchronous, active low; no clearing pass, the buffer is tracked by its fill count
//  config writes are always taken (o_cfg_ready is high)
module utf8_sanitize_copy_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_end_of_text,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_done_res,
    output logic [15:0] o_written_total,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    import u8sc_pkg::*;

    t_cfg   r_cfg, n_cfg;
    t_qword push_word, head_word;
    logic   push, pop, q_full, q_empty;

    assign o_cfg_ready = 1'b1;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_SOURCE_LIMIT: n_cfg.source_limit = i_cfg_data;
                CFG_DEST_LIMIT:   n_cfg.dest_limit   = i_cfg_data;
                default:          n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.source_limit <= SOURCE_LIMIT_RST;
            r_cfg.dest_limit   <= DEST_LIMIT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    u8sc_front u_front (
        .i_in_valid    (i_in_valid),
        .i_data_byte   (i_data_byte),
        .i_end_of_text (i_end_of_text),
        .i_q_full      (q_full),
        .o_in_stall    (o_in_stall),
        .o_push        (push),
        .o_word        (push_word)
    );

    u8sc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_word  (push_word),
        .i_pop   (pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_word  (head_word)
    );

    u8sc_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg           (r_cfg),
        .i_q_empty       (q_empty),
        .i_q_word        (head_word),
        .o_q_pop         (pop),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_out_byte      (o_out_byte),
        .o_done_res      (o_done_res),
        .o_written_total (o_written_total)
    );

endmodule
